@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HFDN_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define HFDN_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define HFDN_ASSERT_IMP(label, ck, rn, ante, cons)

`define HFDN_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

@@ rtl/hfdn_pkg.sv @@
// ---------------------------------------------------------------------------
// hfdn_pkg
// shared types and constants of the hadamard feedback delay network
// ---------------------------------------------------------------------------
package hfdn_pkg;

  localparam int CHANNELS      = 4;
  localparam int CH_BITS       = 2;
  localparam int GAIN_BITS     = 16;
  localparam int FRAC_BITS     = 14;
  localparam int ROUND_BIAS    = 8192;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 64;
  localparam int DELAY_REG_BITS = 60;
  localparam int SLOT_BITS     = 16;
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_BITS  = 2;
  localparam int INFLIGHT_BITS = 3;

  localparam logic [DELAY_REG_BITS-1:0] DELAY_RESET = 60'h0FFF0FFF0FFF0FFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELAY_TAPS     = 8'd0,
    REG_INPUT_GAINS    = 8'd1,
    REG_FEEDBACK_GAINS = 8'd2,
    REG_OUTPUT_GAINS   = 8'd3
  } hfdn_reg_t;

  typedef logic signed [GAIN_BITS-1:0] gain_t;

  typedef struct packed {
    gain_t [CHANNELS-1:0] ig;
    gain_t [CHANNELS-1:0] fb;
    gain_t [CHANNELS-1:0] og;
  } hfdn_gains_t;

  typedef struct packed {
    logic               busy;
    logic [CH_BITS-1:0] phase;
  } hfdn_seq_t;

  // set bit c of row k where the mix sign of tap c is negative
  localparam logic [CHANNELS-1:0][CHANNELS-1:0] MIX_NEG = '{
    4'b1001,
    4'b0011,
    4'b1010,
    4'b0000
  };

  localparam gain_t FB_MAX = 16'sd16384;
  localparam gain_t FB_MIN = -16'sd16384;

endpackage

@@ rtl/hfdn_in_if.sv @@
// ---------------------------------------------------------------------------
// hfdn_in_if
// input sample channel, valid/ready
// ---------------------------------------------------------------------------
interface hfdn_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/hfdn_out_if.sv @@
// ---------------------------------------------------------------------------
// hfdn_out_if
// output sample channel, valid/ready
// ---------------------------------------------------------------------------
interface hfdn_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/hfdn_cfg_if.sv @@
// ---------------------------------------------------------------------------
// hfdn_cfg_if
// register write channel, valid/ready with index and data
// ---------------------------------------------------------------------------
interface hfdn_cfg_if import hfdn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/hfdn_ram.sv @@
// ---------------------------------------------------------------------------
// hfdn_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module hfdn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/hfdn_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// hfdn_cfg_regs
// configuration registers with delay and feedback gain clamping
// ---------------------------------------------------------------------------
module hfdn_cfg_regs import hfdn_pkg::*; #(
  parameter int LINE_DEPTH = 4096,
  localparam int AW        = $clog2(LINE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  hfdn_cfg_if.sink                     cfg_chan,
  output hfdn_gains_t                  gains,
  output logic [CHANNELS-1:0][AW-1:0]  delays
);

  localparam logic [SLOT_BITS:0] DMAX = (SLOT_BITS+1)'(LINE_DEPTH - 1);

  logic [DELAY_REG_BITS-1:0] delay_taps_r;
  logic [CFG_DATA_BITS-1:0]  input_gains_r;
  logic [CFG_DATA_BITS-1:0]  feedback_gains_r;
  logic [CFG_DATA_BITS-1:0]  output_gains_r;
  logic                      wr;
  logic [SLOT_BITS-1:0]      slot [CHANNELS];

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_taps_r     <= DELAY_RESET;
      input_gains_r    <= '0;
      feedback_gains_r <= '0;
      output_gains_r   <= '0;
    end else if (wr) begin
      case (cfg_chan.index)
        REG_DELAY_TAPS:     delay_taps_r     <= cfg_chan.data[DELAY_REG_BITS-1:0];
        REG_INPUT_GAINS:    input_gains_r    <= cfg_chan.data;
        REG_FEEDBACK_GAINS: feedback_gains_r <= cfg_chan.data;
        REG_OUTPUT_GAINS:   output_gains_r   <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < CHANNELS - 1) begin
        slot[c] = delay_taps_r[SLOT_BITS*c +: SLOT_BITS];
      end else begin
        slot[c] = SLOT_BITS'(delay_taps_r[DELAY_REG_BITS-1:SLOT_BITS*(CHANNELS-1)]);
      end
      if (slot[c] == '0) begin
        delays[c] = AW'(1);
      end else if ({1'b0, slot[c]} > DMAX) begin
        delays[c] = DMAX[AW-1:0];
      end else begin
        delays[c] = slot[c][AW-1:0];
      end

      gains.ig[c] = input_gains_r[GAIN_BITS*c +: GAIN_BITS];
      gains.og[c] = output_gains_r[GAIN_BITS*c +: GAIN_BITS];
      gains.fb[c] = feedback_gains_r[GAIN_BITS*c +: GAIN_BITS];
      if ($signed(gains.fb[c]) > FB_MAX) begin
        gains.fb[c] = FB_MAX;
      end else if ($signed(gains.fb[c]) < FB_MIN) begin
        gains.fb[c] = FB_MIN;
      end
    end
  end

endmodule

@@ rtl/hfdn_tap_engine.sv @@
// ---------------------------------------------------------------------------
// hfdn_tap_engine
// channel sequencer: tap reads, feedback products and delay line writes
// ---------------------------------------------------------------------------
module hfdn_tap_engine import hfdn_pkg::*; #(
  parameter int LINE_DEPTH  = 4096,
  parameter int SAMPLE_BITS = 24,
  localparam int AW         = $clog2(LINE_DEPTH),
  localparam int RAW        = AW + CH_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  hfdn_gains_t                          gains,
  input  logic [CHANNELS-1:0][AW-1:0]          delays,
  output hfdn_seq_t                            seq,
  output logic [RAW-1:0]                       rd_addr,
  input  logic [SAMPLE_BITS-1:0]               rd_data,
  output logic                                 wr_en,
  output logic [RAW-1:0]                       wr_addr,
  output logic [SAMPLE_BITS-1:0]               wr_data,
  output logic                                 cap_valid,
  output logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cap_taps
);

  localparam int PW = GAIN_BITS + SAMPLE_BITS;
  localparam logic [AW-1:0]      WP_LAST = AW'(LINE_DEPTH - 1);
  localparam logic [CH_BITS-1:0] PH_LAST = CH_BITS'(CHANNELS - 1);
  localparam logic signed [PW:0] BIAS    = (PW+1)'(ROUND_BIAS);
  localparam logic signed [PW:0] SAT_HI  =
    (PW+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW:0] SAT_LO  = ~SAT_HI;

  logic                          busy_r, busy_nxt;
  logic [CH_BITS-1:0]            phase_r, phase_nxt;
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic                          full_r, full_nxt;
  logic signed [SAMPLE_BITS-1:0] item_x_r;
  logic [AW-1:0]                 item_wp_r;
  logic                          item_full_r;

  logic [AW:0]                   diff;
  logic [AW-1:0]                 rd_idx;
  logic                          rd_ok;

  logic                          s1_vld_r;
  logic [CH_BITS-1:0]            s1_ch_r;
  logic                          s1_ok_r;
  logic signed [SAMPLE_BITS-1:0] s1_x_r;
  logic [AW-1:0]                 s1_wp_r;
  logic signed [SAMPLE_BITS-1:0] tap;
  logic signed [PW-1:0]          p_in, p_fb;

  logic                          s2_vld_r;
  logic [RAW-1:0]                s2_addr_r;
  logic signed [PW-1:0]          p_in_r, p_fb_r;
  logic signed [PW:0]            sum, q;

  logic [CHANNELS-2:0][SAMPLE_BITS-1:0] tap_r;

  // sequencer, one channel per cycle
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      phase_nxt = '0;
    end else if (busy_r) begin
      phase_nxt = phase_r + CH_BITS'(1);
      if (phase_r == PH_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    wp_nxt   = wp_r;
    full_nxt = full_r;
    if (accept) begin
      if (wp_r == WP_LAST) begin
        wp_nxt   = '0;
        full_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
      wp_r    <= '0;
      full_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_x_r    <= sample;
      item_wp_r   <= wp_r;
      item_full_r <= full_r;
    end
  end

  assign seq.busy  = busy_r;
  assign seq.phase = phase_r;

  // tap address, entries not yet written since reset read as zero
  always_comb begin
    diff = {1'b0, item_wp_r} - {1'b0, delays[phase_r]};
    if (diff[AW]) begin
      rd_idx = diff[AW-1:0] + AW'(LINE_DEPTH);
    end else begin
      rd_idx = diff[AW-1:0];
    end
    rd_ok = item_full_r || !diff[AW];
  end

  assign rd_addr = {phase_r, rd_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= busy_r;
    end
    s1_ch_r <= phase_r;
    s1_ok_r <= rd_ok;
    s1_x_r  <= item_x_r;
    s1_wp_r <= item_wp_r;
  end

  assign tap  = s1_ok_r ? $signed(rd_data) : '0;
  assign p_in = $signed(gains.ig[s1_ch_r]) * s1_x_r;
  assign p_fb = $signed(gains.fb[s1_ch_r]) * tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_addr_r <= {s1_ch_r, s1_wp_r};
    p_in_r    <= p_in;
    p_fb_r    <= p_fb;
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_ch_r != PH_LAST) begin
      tap_r[s1_ch_r] <= tap;
    end
  end

  // round half up, saturate, write back
  always_comb begin
    sum = p_in_r + p_fb_r + BIAS;
    q   = sum >>> FRAC_BITS;
    if (q > SAT_HI) begin
      wr_data = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      wr_data = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      wr_data = q[SAMPLE_BITS-1:0];
    end
  end

  assign wr_en   = s2_vld_r;
  assign wr_addr = s2_addr_r;

  assign cap_valid = s1_vld_r && (s1_ch_r == PH_LAST);

  always_comb begin
    for (int c = 0; c < CHANNELS - 1; c++) begin
      cap_taps[c] = tap_r[c];
    end
    cap_taps[CHANNELS-1] = tap;
  end

endmodule

@@ rtl/hfdn_mixer.sv @@
// ---------------------------------------------------------------------------
// hfdn_mixer
// hadamard mix of the taps, output gain accumulation and output queue
// ---------------------------------------------------------------------------
module hfdn_mixer import hfdn_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cap_valid,
  input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cap_taps,
  input  hfdn_gains_t                          gains,
  hfdn_out_if.source                           out_chan
);

  localparam int MW  = SAMPLE_BITS + 2;
  localparam int PRW = GAIN_BITS + MW;
  localparam int ACW = PRW + 3;
  localparam logic [CH_BITS-1:0]  K_LAST = CH_BITS'(CHANNELS - 1);
  localparam logic signed [ACW-1:0] BIAS   = ACW'(ROUND_BIAS);
  localparam logic signed [ACW-1:0] SAT_HI =
    ACW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACW-1:0] SAT_LO = ~SAT_HI;

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] mix_tap_r;
  logic                    act_r, act_nxt;
  logic [CH_BITS-1:0]      k_r, k_nxt;

  logic signed [MW-1:0]    m_sum;
  logic                    ma_vld_r;
  logic [CH_BITS-1:0]      ma_k_r;
  logic signed [MW-1:0]    m_r;

  logic signed [PRW-1:0]   prod;
  logic                    pb_vld_r;
  logic [CH_BITS-1:0]      pb_k_r;
  logic signed [PRW-1:0]   prod_r;

  logic signed [ACW-1:0]   acc_r, acc_nxt;
  logic                    last_r;
  logic signed [ACW-1:0]   q;
  logic [SAMPLE_BITS-1:0]  res;

  logic [SAMPLE_BITS-1:0]  fifo_r [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [INFLIGHT_BITS-1:0] cnt_r;
  logic                    push, pop;

  always_ff @(posedge clk) begin
    if (cap_valid) begin
      mix_tap_r <= cap_taps;
    end
  end

  // one mix row per cycle
  always_comb begin
    act_nxt = act_r;
    k_nxt   = k_r;
    if (cap_valid) begin
      act_nxt = 1'b1;
      k_nxt   = '0;
    end else if (act_r) begin
      k_nxt = k_r + CH_BITS'(1);
      if (k_r == K_LAST) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    m_sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (MIX_NEG[k_r][c]) begin
        m_sum = m_sum - MW'($signed(mix_tap_r[c]));
      end else begin
        m_sum = m_sum + MW'($signed(mix_tap_r[c]));
      end
    end
  end

  assign prod    = $signed(gains.og[ma_k_r]) * m_r;
  assign acc_nxt = ((pb_k_r == '0) ? BIAS : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      k_r      <= '0;
      ma_vld_r <= 1'b0;
      pb_vld_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      k_r      <= k_nxt;
      ma_vld_r <= act_r;
      pb_vld_r <= ma_vld_r;
      last_r   <= pb_vld_r && (pb_k_r == K_LAST);
    end
    ma_k_r <= k_r;
    m_r    <= m_sum;
    pb_k_r <= ma_k_r;
    prod_r <= prod;
    if (pb_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    q = acc_r >>> FRAC_BITS;
    if (q > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = q[SAMPLE_BITS-1:0];
    end
  end

  // output queue
  assign push = last_r;
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_BITS'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + INFLIGHT_BITS'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - INFLIGHT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_chan.valid      = (cnt_r != '0);
  assign out_chan.sample_out = $signed(fifo_r[rd_ptr_r]);

endmodule

@@ rtl/hadamard_feedback_delay_network.sv @@
// ---------------------------------------------------------------------------
// hadamard_feedback_delay_network
// Four channel feedback delay network with an unnormalized 4x4 Hadamard
// output mix. One input sample gives one output sample. A new sample is
// taken only once the previous one reaches its last channel: the four
// channel taps are read one per cycle through the single read port of the
// delay memory, and the write-back of each channel goes through the single
// write port in the same rotation. Up to four samples are in flight, backed
// by a four entry output queue. The delay memory is not swept after reset:
// a wrap flag on the write position makes every entry not yet written read
// as zero, so samples are taken right after reset. The user must write
// registers through the cfg channel only while no sample is in flight; the
// block itself does not enforce this.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hadamard_feedback_delay_network import hfdn_pkg::*; #(
  parameter int LINE_DEPTH  = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  hfdn_in_if.sink    in_chan,
  hfdn_out_if.source out_chan,
  hfdn_cfg_if.sink   cfg_chan
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int RAW = AW + CH_BITS;
  localparam int MEM_DEPTH = CHANNELS << AW;
  localparam logic [CH_BITS-1:0] PH_LAST = CH_BITS'(CHANNELS - 1);

  hfdn_gains_t                          gains;
  logic [CHANNELS-1:0][AW-1:0]          delays;
  hfdn_seq_t                            seq;
  logic                                 in_accept;
  logic                                 out_pop;
  logic [INFLIGHT_BITS-1:0]             inflight_r, inflight_nxt;
  logic [RAW-1:0]                       rd_addr, wr_addr;
  logic [SAMPLE_BITS-1:0]               rd_data, wr_data;
  logic                                 wr_en;
  logic                                 cap_valid;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cap_taps;

  assign in_chan.ready = (!seq.busy || seq.phase == PH_LAST) &&
                         (inflight_r < INFLIGHT_BITS'(OUT_DEPTH));
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign out_pop       = out_chan.valid && out_chan.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_accept && !out_pop) begin
      inflight_nxt = inflight_r + INFLIGHT_BITS'(1);
    end else if (out_pop && !in_accept) begin
      inflight_nxt = inflight_r - INFLIGHT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  hfdn_cfg_regs #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .gains    (gains),
    .delays   (delays)
  );

  hfdn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_delay_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hfdn_tap_engine #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tap_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .sample    (in_chan.sample_in),
    .gains     (gains),
    .delays    (delays),
    .seq       (seq),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cap_valid (cap_valid),
    .cap_taps  (cap_taps)
  );

  hfdn_mixer #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mixer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_valid (cap_valid),
    .cap_taps  (cap_taps),
    .gains     (gains),
    .out_chan  (out_chan)
  );

  // a request starts the channel rotation at channel zero
  `HFDN_ASSERT_NXT(a_accept_starts, clk, rst_n, in_accept, seq.busy && seq.phase == '0)
  // the rotation steps one channel per cycle
  `HFDN_ASSERT_NXT(a_phase_step, clk, rst_n, seq.busy && seq.phase != PH_LAST && !in_accept, seq.busy && seq.phase == $past(seq.phase) + CH_BITS'(1))
  // no result leaves without a sample in flight
  `HFDN_ASSERT_IMP(a_out_has_item, clk, rst_n, out_pop, inflight_r != '0)
  // the in-flight count never passes the output queue depth
  `HFDN_ASSERT_IMP(a_inflight_bound, clk, rst_n, 1'b1, inflight_r <= INFLIGHT_BITS'(OUT_DEPTH))

endmodule
